// File: hdl/rwsr_pkg.sv
package rwsr_pkg;

  localparam int NUM_PARTICLES = 1024;
  localparam int PART_AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

  localparam int IDX_W = 10;
  localparam int ANG_W = 16;
  localparam int POS_W = 32;
  localparam int LEN_W = 16;
  localparam int LIM_W = 31;
  localparam int CFG_W = 32;
  localparam int IN_W = 48;   // 42 bits of fields, zero filled to 6 bytes
  localparam int OUT_W = 112; // 106 bits of fields, zero filled to 14 bytes

  // CORDIC: Q1.30 vectors, angles in 2^32 per turn
  localparam int CORDIC_ITERS = 24;
  localparam int CORDIC_LAT = CORDIC_ITERS + 2;
  localparam int CW = 34;
  localparam int ZW = 34;
  localparam int TRIG_W = 32;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int DISP_W = 20;  // Q3.16 displacement, |d| < 2^16

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = 2;

  typedef enum logic [1:0] {
    REG_STEP_LENGTH = 2'd0,
    REG_X_LIMIT     = 2'd1,
    REG_Y_LIMIT     = 2'd2,
    REG_Z_LIMIT     = 2'd3
  } reg_index_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } back_state_t;

  typedef struct packed {
    logic [LEN_W-1:0] step_length;
    logic [LIM_W-1:0] x_limit;
    logic [LIM_W-1:0] y_limit;
    logic [LIM_W-1:0] z_limit;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic                     ok;
    logic signed [DISP_W-1:0] dx;
    logic signed [DISP_W-1:0] dy;
    logic signed [DISP_W-1:0] dz;
  } step_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    case (i)
      0:  return 34'sd536870912;
      1:  return 34'sd316933406;
      2:  return 34'sd167458907;
      3:  return 34'sd85004756;
      4:  return 34'sd42667331;
      5:  return 34'sd21354465;
      6:  return 34'sd10679838;
      7:  return 34'sd5340245;
      8:  return 34'sd2670163;
      9:  return 34'sd1335087;
      10: return 34'sd667544;
      11: return 34'sd333772;
      12: return 34'sd166886;
      13: return 34'sd83443;
      14: return 34'sd41722;
      15: return 34'sd20861;
      16: return 34'sd10430;
      17: return 34'sd5215;
      18: return 34'sd2608;
      19: return 34'sd1304;
      20: return 34'sd652;
      21: return 34'sd326;
      22: return 34'sd163;
      23: return 34'sd81;
      default: return '0;
    endcase
  endfunction

endpackage

// File: hdl/rwsr_cordic.sv
module rwsr_cordic
  import rwsr_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic [31:0]              angle,
  output logic signed [TRIG_W-1:0] sin_out,
  output logic signed [TRIG_W-1:0] cos_out
);

  logic signed [CW-1:0] xs [0:CORDIC_ITERS];
  logic signed [CW-1:0] ys [0:CORDIC_ITERS];
  logic signed [ZW-1:0] zs [0:CORDIC_ITERS];
  logic                 fl [0:CORDIC_ITERS];

  logic [31:0]          turned;
  logic                 flip_in;
  logic [31:0]          folded;
  logic signed [CW-1:0] y_sel;
  logic signed [CW-1:0] x_sel;

  // fold into [-1/4, 1/4) turn by a half turn, results negated at the end
  assign turned  = angle + 32'h4000_0000;
  assign flip_in = turned[31];
  assign folded  = {angle[31] ^ flip_in, angle[30:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CORDIC_GAIN;
      ys[0] <= '0;
      zs[0] <= {{(ZW-32){folded[31]}}, folded};
      fl[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][ZW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_turn(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_turn(i);
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  assign y_sel = fl[CORDIC_ITERS] ? -ys[CORDIC_ITERS] : ys[CORDIC_ITERS];
  assign x_sel = fl[CORDIC_ITERS] ? -xs[CORDIC_ITERS] : xs[CORDIC_ITERS];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_out <= y_sel[TRIG_W-1:0];
      cos_out <= x_sel[TRIG_W-1:0];
    end
  end

endmodule

// File: hdl/rwsr_front.sv
module rwsr_front
  import rwsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IDX_W-1:0] in_index,
  input  logic [ANG_W-1:0] in_azimuth,
  input  logic [ANG_W-1:0] in_polar,
  input  logic             blocked,
  input  logic [LEN_W-1:0] step_length,
  input  logic             q_full,
  output logic             push,
  output step_t            push_data
);

  logic en;
  logic take;
  logic [31:0] theta;
  logic [31:0] phi;
  logic signed [TRIG_W-1:0] st, ct, sp, cp;

  logic             vld [0:CORDIC_LAT-1];
  logic [IDX_W-1:0] idl [0:CORDIC_LAT-1];

  logic                     m1_vld;
  logic [IDX_W-1:0]         m1_idx;
  logic signed [TRIG_W-1:0] m1_pc, m1_ps, m1_cp;
  logic signed [63:0]       pc_full, ps_full, pc_rnd, ps_rnd;

  logic                     m2_vld;
  step_t                    m2;
  logic signed [49:0]       dx_full, dy_full, dz_full;
  logic signed [49:0]       len_s;

  // the whole front moves as one; it stops only when the queue is full
  assign en       = !q_full;
  assign in_ready = en && !blocked;
  assign take     = in_valid && in_ready;

  assign theta = {in_azimuth, 16'h0000};
  assign phi   = {1'b0, in_polar, 15'h0000};

  rwsr_cordic u_theta (.clk(clk), .en(en), .angle(theta), .sin_out(st), .cos_out(ct));
  rwsr_cordic u_phi   (.clk(clk), .en(en), .angle(phi),   .sin_out(sp), .cos_out(cp));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CORDIC_LAT; k++) vld[k] <= 1'b0;
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
    end else if (en) begin
      vld[0] <= take;
      for (int k = 1; k < CORDIC_LAT; k++) vld[k] <= vld[k-1];
      m1_vld <= vld[CORDIC_LAT-1];
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idl[0] <= in_index;
      for (int k = 1; k < CORDIC_LAT; k++) idl[k] <= idl[k-1];
    end
  end

  // Q2.60 products rounded back to Q1.30
  assign pc_full = ct * sp;
  assign ps_full = st * sp;
  assign pc_rnd  = pc_full + 64'sd536870912;
  assign ps_rnd  = ps_full + 64'sd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_idx <= idl[CORDIC_LAT-1];
      m1_pc  <= pc_rnd[61:30];
      m1_ps  <= ps_rnd[61:30];
      m1_cp  <= cp;
    end
  end

  // step length Q0.16 times Q1.30, rounded to Q3.16
  assign len_s   = $signed({34'd0, step_length});
  assign dx_full = len_s * 50'(m1_pc) + 50'sd536870912;
  assign dy_full = len_s * 50'(m1_ps) + 50'sd536870912;
  assign dz_full = len_s * 50'(m1_cp) + 50'sd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      m2.idx <= m1_idx;
      m2.ok  <= int'(m1_idx) < NUM_PARTICLES;
      m2.dx  <= dx_full[49:30];
      m2.dy  <= dy_full[49:30];
      m2.dz  <= dz_full[49:30];
    end
  end

  assign push      = en && m2_vld;
  assign push_data = m2;

endmodule

// File: hdl/rwsr_queue.sv
module rwsr_queue
  import rwsr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  step_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output step_t head
);

  step_t          slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full     = count == (Q_AW+1)'(Q_DEPTH);
  assign nonempty = count != '0;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: hdl/rwsr_back.sv
module rwsr_back
  import rwsr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    q_nonempty,
  output logic                    q_pop,
  input  step_t                   head,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        out_index,
  output logic signed [POS_W-1:0] out_x,
  output logic signed [POS_W-1:0] out_y,
  output logic signed [POS_W-1:0] out_z,
  output logic                    busy
);

  back_state_t state, state_next;
  logic [PART_AW-1:0] clr_addr;
  logic               clr_last;

  logic signed [POS_W-1:0] mem_x [NUM_PARTICLES];
  logic signed [POS_W-1:0] mem_y [NUM_PARTICLES];
  logic signed [POS_W-1:0] mem_z [NUM_PARTICLES];

  logic                    b_valid;
  step_t                   b;
  logic signed [POS_W-1:0] rd_x, rd_y, rd_z;

  logic                    fwd_valid;
  logic [IDX_W-1:0]        fwd_idx;
  logic signed [POS_W-1:0] fwd_x, fwd_y, fwd_z;
  logic                    fwd_hit;

  logic                    o_load, b_move;
  logic signed [POS_W-1:0] old_x, old_y, old_z;
  logic signed [POS_W-1:0] nx, ny, nz;

  logic                    we;
  logic [PART_AW-1:0]      waddr;
  logic signed [POS_W-1:0] wx, wy, wz;

  function automatic logic signed [POS_W-1:0] reflect(
    input logic signed [POS_W-1:0]  old,
    input logic signed [DISP_W-1:0] d,
    input logic [LIM_W-1:0]         lim
  );
    logic signed [34:0] v, l, r;
    v = 35'(old) + 35'(d);
    l = $signed({4'b0000, lim});
    if (v > l)       r = (l <<< 1) - v;
    else if (v < -l) r = -(l <<< 1) - v;
    else             r = v;
    if (r > 35'sd2147483647)       r = 35'sd2147483647;
    else if (r < -35'sd2147483648) r = -35'sd2147483648;
    return r[POS_W-1:0];
  endfunction

  // clearing sweep after reset
  assign clr_last = clr_addr == PART_AW'(NUM_PARTICLES - 1);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    case (state)
      ST_CLEAR: begin
        busy = 1'b1;
        if (clr_last) state_next = ST_RUN;
      end
      ST_RUN: state_next = ST_RUN;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)       clr_addr <= '0;
    else if (busy) clr_addr <= clr_addr + 1'b1;
  end

  // B holds the item and its read data; O is the output register
  assign o_load = b_valid && (!out_valid || out_ready);
  assign b_move = !b_valid || o_load;
  assign q_pop  = q_nonempty && b_move && !busy;

  // the write at the same edge as this item's read is not in rd_*
  assign fwd_hit = fwd_valid && (fwd_idx == b.idx);
  assign old_x   = fwd_hit ? fwd_x : rd_x;
  assign old_y   = fwd_hit ? fwd_y : rd_y;
  assign old_z   = fwd_hit ? fwd_z : rd_z;

  assign nx = b.ok ? reflect(old_x, b.dx, cfg.x_limit) : '0;
  assign ny = b.ok ? reflect(old_y, b.dy, cfg.y_limit) : '0;
  assign nz = b.ok ? reflect(old_z, b.dz, cfg.z_limit) : '0;

  assign we    = busy || (o_load && b.ok);
  assign waddr = busy ? clr_addr : b.idx[PART_AW-1:0];
  assign wx    = busy ? '0 : nx;
  assign wy    = busy ? '0 : ny;
  assign wz    = busy ? '0 : nz;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
      mem_z[waddr] <= wz;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      rd_x <= mem_x[head.idx[PART_AW-1:0]];
      rd_y <= mem_y[head.idx[PART_AW-1:0]];
      rd_z <= mem_z[head.idx[PART_AW-1:0]];
      b    <= head;
      fwd_idx <= b.idx;
      fwd_x   <= nx;
      fwd_y   <= ny;
      fwd_z   <= nz;
    end
    if (o_load) begin
      out_index <= b.idx;
      out_x     <= nx;
      out_y     <= ny;
      out_z     <= nz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_move) begin
        b_valid   <= q_pop;
        fwd_valid <= o_load && b.ok;
      end
      if (o_load)         out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// File: hdl/random_walk_step_reflect_top.sv
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata: particle_index, azimuth, polar
// m        out  m_tvalid/m_tready  m_tdata: stepped_index, new_x, new_y, new_z
// cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One step per cycle sustained while m_tready stays high; from s transfer to m valid
// a step passes two CORDIC pipes, two multiply stages, queue, position RAM read, reflect.
// After reset the position RAMs are swept to zero, with s_tready low during the sweep.
// A 4-entry queue parts the trig front from the RAM back; the front stalls only on
// a full queue, the back only on m_tready. Back-to-back steps of one particle are
// forwarded around the RAM read.
module random_walk_step_reflect_top
  import rwsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // particle_index[9:0], azimuth[25:10], polar[41:26]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // stepped_index[9:0], new_x[41:10],
                                      // new_y[73:42], new_z[105:74]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t cfg;

  logic  busy;
  logic  q_full, q_push, q_pop, q_nonempty;
  step_t q_in, q_head;

  logic [IDX_W-1:0]        out_index;
  logic signed [POS_W-1:0] out_x, out_y, out_z;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_length <= LEN_W'(1638);
      cfg.x_limit     <= LIM_W'(65536);
      cfg.y_limit     <= LIM_W'(65536);
      cfg.z_limit     <= LIM_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_STEP_LENGTH: cfg.step_length <= cfg_data[LEN_W-1:0];
        REG_X_LIMIT:     cfg.x_limit     <= cfg_data[LIM_W-1:0];
        REG_Y_LIMIT:     cfg.y_limit     <= cfg_data[LIM_W-1:0];
        REG_Z_LIMIT:     cfg.z_limit     <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // front: angles to displacements
  rwsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_index   (s_tdata[9:0]),
    .in_azimuth (s_tdata[25:10]),
    .in_polar   (s_tdata[41:26]),
    .blocked    (busy),
    .step_length(cfg.step_length),
    .q_full     (q_full),
    .push       (q_push),
    .push_data  (q_in)
  );

  rwsr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  // back: position RAM update, reflection, output register
  rwsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_nonempty(q_nonempty),
    .q_pop     (q_pop),
    .head      (q_head),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_index (out_index),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .busy      (busy)
  );

  assign m_tdata = {6'b000000, out_z, out_y, out_x, out_index};

`ifndef SYNTHESIS
  // no transfer in while the RAMs are being cleared
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready)
    else $error("input taken during clear sweep");

  // no result before the clear sweep ends
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !m_tvalid)
    else $error("result during clear sweep");

  // the queue never receives an item while full
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue overflow");
`endif

endmodule

// File: tb/testbench.sv
module testbench;
  import rwsr_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // dut ports
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  random_walk_step_reflect_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } position_t;

  // predictor state: config shadow and particle positions
  logic [LEN_W-1:0]        step_len_sh;
  logic [LIM_W-1:0]        lim_sh[3];
  logic signed [POS_W-1:0] pos_sh[3][NUM_PARTICLES];

  position_t expected_positions[$];
  int  errors = 0;
  int  cycles = 0;
  int  send_idle_pct = 0;   // chance per cycle that the sender holds off
  int  recv_stall_pct = 0;  // chance per cycle that m_tready is low

  localparam longint TURN_GAIN = 652032874;
  localparam longint MAX_CYCLES = 2_000_000;

  // CORDIC atan table, 2^32 per turn
  longint atan_lut[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81};

  // >>> on longint is arithmetic: floor division by 2^n
  task automatic trig(input logic [31:0] ang, output longint s, output longint c);
    logic        flip;
    logic [31:0] b;
    longint      x, y, zz, xs, ys;
    flip = ang[31] ^ ang[30];  // (a + quarter turn) has its top bit set
    b = flip ? ang - 32'h8000_0000 : ang;
    zz = longint'($signed(b));
    x = TURN_GAIN;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (zz >= 0) begin
        x -= ys; y += xs; zz -= atan_lut[i];
      end else begin
        x += ys; y -= xs; zz += atan_lut[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint scale_step(longint q30);
    return (longint'(step_len_sh) * q30 + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [POS_W-1:0] reflect(longint old, longint d, longint lim);
    longint v;
    v = old + d;
    if (v > lim) v = 2 * lim - v;
    else if (v < -lim) v = -2 * lim - v;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic predict_step(input logic [IDX_W-1:0] idx, input logic [15:0] az,
                              input logic [15:0] pol);
    position_t p;
    longint st, ct, sp, cp;
    longint d[3];
    p.idx = idx;
    p.x = 0; p.y = 0; p.z = 0;
    if (idx < NUM_PARTICLES) begin
      trig({az, 16'h0}, st, ct);
      trig({1'b0, pol, 15'h0}, sp, cp);
      d[0] = scale_step((ct * sp + (64'sd1 <<< 29)) >>> 30);
      d[1] = scale_step((st * sp + (64'sd1 <<< 29)) >>> 30);
      d[2] = scale_step(cp);
      p.x = reflect(pos_sh[0][idx], d[0], lim_sh[0]);
      p.y = reflect(pos_sh[1][idx], d[1], lim_sh[1]);
      p.z = reflect(pos_sh[2][idx], d[2], lim_sh[2]);
      pos_sh[0][idx] = p.x;
      pos_sh[1][idx] = p.y;
      pos_sh[2][idx] = p.z;
    end
    expected_positions.insert(expected_positions.size(), p);
  endtask

  // one transfer on the step input; the predictor runs at acceptance.
  // s_tvalid stays high afterwards until the next idle cycle or a pause.
  task automatic send_step(input logic [IDX_W-1:0] idx, input logic [15:0] az,
                           input logic [15:0] pol);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {6'h0, pol, az, idx};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_step(idx, az, pol);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_positions.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // only called while idle, after drain; set_box drops cfg_valid
  task automatic write_reg(input reg_index_t r, input logic [CFG_W-1:0] val);
    cfg_index <= r;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      REG_STEP_LENGTH: step_len_sh = val[LEN_W-1:0];
      REG_X_LIMIT:     lim_sh[0] = val[LIM_W-1:0];
      REG_Y_LIMIT:     lim_sh[1] = val[LIM_W-1:0];
      default:         lim_sh[2] = val[LIM_W-1:0];
    endcase
    @(negedge clk);
  endtask

  task automatic set_box(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] lx,
                         input logic [CFG_W-1:0] ly, input logic [CFG_W-1:0] lz);
    write_reg(REG_STEP_LENGTH, len);
    write_reg(REG_X_LIMIT, lx);
    write_reg(REG_Y_LIMIT, ly);
    write_reg(REG_Z_LIMIT, lz);
    cfg_valid <= 1'b0;
  endtask

  // extreme angles, index bits and all four axes of each angle
  task automatic test_directed();
    logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                             16'hFFFF, 16'h3FFF, 16'h7FFF, 16'h5555};
    for (int i = 0; i < 8; i++) send_step(10'd0, angs[i], angs[7 - i]);
    send_step(10'h3FF, 16'hFFFF, 16'hFFFF);
    send_step(10'h2AA, 16'h2000, 16'h4000);
    send_step(10'h155, 16'hA000, 16'hC000);
    send_step(10'h3FF, 16'h0000, 16'h0000);
    drain();
  endtask

  // long step in a tiny box: one reflection leaves values outside
  task automatic test_small_box();
    set_box(32'hFFFF, 32'd100, 32'd0, 32'd1);
    for (int i = 0; i < 12; i++) send_step(IDX_W'(i % 2), 16'($urandom), 16'($urandom));
    drain();
  endtask

  // widest walls: reflection never fires, one particle steps along a fixed direction
  task automatic test_wide_box();
    set_box(32'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    for (int i = 0; i < 10; i++) send_step(10'd5, 16'h0000, 16'h4000);
    drain();
  endtask

  // random walks on a few hot particles plus spread over all of them
  task automatic test_random(input int n);
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < n; i++) begin
      idx = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(1023)) :
                                       IDX_W'($urandom_range(7));
      send_step(idx, 16'($urandom), 16'($urandom));
      // let the pipe run dry once to cover an empty-pipeline restart
      if (i == n / 2) begin
        s_tvalid <= 1'b0;
        while (expected_positions.size() != 0) @(negedge clk);
      end
    end
    drain();
  endtask

  // result checker; m_tready is redrawn every falling edge
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    position_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_positions.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        e = expected_positions.pop_front();
        if (m_tdata[9:0] !== e.idx || $signed(m_tdata[41:10]) !== e.x ||
            $signed(m_tdata[73:42]) !== e.y || $signed(m_tdata[105:74]) !== e.z ||
            m_tdata[111:106] !== 6'h0) begin
          $display("%0t: expected idx %0d x %0d y %0d z %0d, got idx %0d x %0d y %0d z %0d",
                   $time, e.idx, e.x, e.y, e.z, m_tdata[9:0], $signed(m_tdata[41:10]),
                   $signed(m_tdata[73:42]), $signed(m_tdata[105:74]));
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    step_len_sh = 16'd1638;
    for (int a = 0; a < 3; a++) begin
      lim_sh[a] = 31'd65536;
      for (int i = 0; i < NUM_PARTICLES; i++) pos_sh[a][i] = '0;
    end
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset defaults first, then sender idles 20% / receiver 45%
    send_idle_pct = 20; recv_stall_pct = 45;
    test_directed();
    test_small_box();
    set_box(32'd1638, 32'd65536, 32'd65536, 32'd65536);
    test_random(480);
    // swap the idle pattern
    send_idle_pct = 45; recv_stall_pct = 20;
    test_wide_box();
    set_box(32'd20000, 32'd30000, 32'd200000, 32'd5000);
    test_random(480);
    // full rate
    send_idle_pct = 0; recv_stall_pct = 0;
    set_box(32'd0, 32'd0, 32'd0, 32'd0);
    test_random(20);
    set_box(32'd4000, 32'd65536, 32'd40000, 32'd100000);
    test_random(430);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/rwsr_pkg.sv
hdl/rwsr_cordic.sv
hdl/rwsr_front.sv
hdl/rwsr_queue.sv
hdl/rwsr_back.sv
hdl/random_walk_step_reflect_top.sv
tb/testbench.sv
